FILE: rtl/gmcm_pkg.sv
// ----------------------------------------------------------------------------
// gmcm_pkg
// Shared widths, constants, types and the square-root digit step for the
// gated mean complex magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmcm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 32;
  localparam int MAG_W       = 16;
  localparam int THR_W       = 16;
  localparam int SUM_W       = 29;
  localparam int MAX_FRAME   = 4096;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int SQRT_STAGES = SQ_W / 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int STEP_W      = $clog2(MAG_W);
  localparam int REM_W       = MAG_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(46340);

  // byte address of the threshold register
  localparam logic [1:0] THR_ADDR = 2'd0;

  // one magnitude word on its way from front to back
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
  } mag_item_t;

  // partial remainder and root of the digit-by-digit square root
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] root;
  } sqrt_acc_t;

  // one root bit: bring down two radicand bits, try (4*root + 1)
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    sqrt_acc_t        o;
    r = {a.rem, pair};
    t = {1'b0, a.root, 2'b01};
    if (r >= t) begin
      o.rem  = REM_W'(r - t);
      o.root = {a.root[MAG_W-2:0], 1'b1};
    end else begin
      o.rem  = r[REM_W-1:0];
      o.root = {a.root[MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gmcm_front.sv
// ----------------------------------------------------------------------------
// gmcm_front
// Magnitude pipeline: squares, sum of squares, then an eight-stage square
// root giving two root bits per stage. The whole pipe holds when its last
// stage is full and the queue cannot take the word.
// ----------------------------------------------------------------------------
`default_nettype none

module gmcm_front
  import gmcm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] real_part,
  input  wire logic signed [SAMPLE_W-1:0] imag_part,
  input  wire logic                       frame_end,
  output logic                            mag_valid,
  output mag_item_t                       mag_item,
  input  wire logic                       mag_ready
);

  logic                   en;
  logic [SQ_W-2:0]        re2_r;
  logic [SQ_W-2:0]        im2_r;
  logic                   sq_v_r;
  logic                   sq_last_r;
  logic [SQ_W-1:0]        x_r;
  logic                   x_v_r;
  logic                   x_last_r;
  logic signed [SQ_W-1:0] re_prod;
  logic signed [SQ_W-1:0] im_prod;

  sqrt_acc_t       st_acc_r  [SQRT_STAGES];
  logic [SQ_W-1:0] st_x_r    [SQRT_STAGES];
  logic            st_v_r    [SQRT_STAGES];
  logic            st_last_r [SQRT_STAGES];
  sqrt_acc_t       st_acc_nxt[SQRT_STAGES];

  assign en       = !st_v_r[SQRT_STAGES-1] || mag_ready;
  assign in_ready = en;

  assign re_prod = real_part * real_part;
  assign im_prod = imag_part * imag_part;

  always_comb begin
    sqrt_acc_t a;
    sqrt_acc_t b;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        a = '0;
        a = sqrt_step(a, x_r[SQ_W-1 -: 2]);
        b = sqrt_step(a, x_r[SQ_W-3 -: 2]);
      end else begin
        a = sqrt_step(st_acc_r[k-1], st_x_r[k-1][SQ_W-1-4*k -: 2]);
        b = sqrt_step(a, st_x_r[k-1][SQ_W-3-4*k -: 2]);
      end
      st_acc_nxt[k] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      x_v_r  <= 1'b0;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        st_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      sq_v_r <= in_valid;
      x_v_r  <= sq_v_r;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        st_v_r[k] <= (k == 0) ? x_v_r : st_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re2_r     <= re_prod[SQ_W-2:0];
      im2_r     <= im_prod[SQ_W-2:0];
      sq_last_r <= frame_end;
      x_r       <= {1'b0, re2_r} + {1'b0, im2_r};
      x_last_r  <= sq_last_r;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        st_acc_r[k]  <= st_acc_nxt[k];
        st_x_r[k]    <= (k == 0) ? x_r : st_x_r[k-1];
        st_last_r[k] <= (k == 0) ? x_last_r : st_last_r[k-1];
      end
    end
  end

  assign mag_valid     = st_v_r[SQRT_STAGES-1];
  assign mag_item.mag  = st_acc_r[SQRT_STAGES-1].root;
  assign mag_item.last = st_last_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/gmcm_fifo.sv
// ----------------------------------------------------------------------------
// gmcm_fifo
// Short queue of magnitude words between the magnitude pipeline and the
// accumulator, so that the divider can stall the back end on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module gmcm_fifo
  import gmcm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire mag_item_t push_item,
  output logic           pop_valid,
  output mag_item_t      pop_item,
  input  wire logic      pop
);

  mag_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gmcm_back.sv
// ----------------------------------------------------------------------------
// gmcm_back
// Gated accumulation of magnitudes with frame length count, a radix-2
// divider for the frame mean and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gmcm_back
  import gmcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [THR_W-1:0] threshold,
  input  wire logic             q_valid,
  input  wire mag_item_t        q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [MAG_W-1:0]      mean_magnitude,
  output logic                  frame_overflow
);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t         div_state_r, div_state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   div_rem_r, div_rem_nxt;
  logic [MAG_W-1:0]   div_q_r, div_q_nxt;
  logic [CNT_W-1:0]   div_dsr_r, div_dsr_nxt;
  logic [STEP_W-1:0]  div_step_r, div_step_nxt;
  logic               div_ovf_r, div_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0]   out_mean_r, out_mean_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               pop;
  logic               sat;
  logic               gated;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   acc_cnt;
  logic               acc_ovf;
  logic [CNT_W:0]     trial;
  logic               ge;

  // a frame end may leave the queue only when the divider is free
  assign pop   = q_valid && (!q_item.last || div_state_r == DIV_IDLE);
  assign q_pop = pop;

  assign sat     = cnt_r >= CNT_W'(MAX_FRAME);
  assign gated   = (threshold != '0) && (q_item.mag > threshold);
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(q_item.mag);
  assign sum_sat = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];

  assign trial = {div_rem_r, div_q_r[MAG_W-1]};
  assign ge    = trial >= {1'b0, div_dsr_r};

  always_comb begin
    acc_sum = sum_r;
    acc_cnt = cnt_r;
    acc_ovf = ovf_r;
    if (sat) begin
      acc_ovf = 1'b1;
    end else begin
      acc_cnt = cnt_r + 1'b1;
      if (!gated) begin
        acc_sum = sum_sat;
      end
    end
  end

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    div_state_nxt = div_state_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    div_dsr_nxt   = div_dsr_r;
    div_step_nxt  = div_step_r;
    div_ovf_nxt   = div_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mean_nxt  = out_mean_r;
    out_ovf_nxt   = out_ovf_r;

    if (pop) begin
      if (q_item.last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = acc_sum;
        cnt_nxt = acc_cnt;
        ovf_nxt = acc_ovf;
      end
    end

    case (div_state_r)
      DIV_IDLE: begin
        if (pop && q_item.last) begin
          div_dsr_nxt  = acc_cnt;
          div_ovf_nxt  = acc_ovf;
          div_step_nxt = STEP_W'(MAG_W - 1);
          if (acc_cnt == '0) begin
            div_q_nxt     = '0;
            div_state_nxt = DIV_DONE;
          end else begin
            // upper dividend bits start the remainder: the mean fits MAG_W bits
            div_rem_nxt   = CNT_W'(acc_sum >> MAG_W);
            div_q_nxt     = acc_sum[MAG_W-1:0];
            div_state_nxt = DIV_RUN;
          end
        end
      end
      DIV_RUN: begin
        div_rem_nxt = ge ? CNT_W'(trial - {1'b0, div_dsr_r}) : CNT_W'(trial);
        div_q_nxt   = {div_q_r[MAG_W-2:0], ge};
        if (div_step_r == '0) begin
          div_state_nxt = DIV_DONE;
        end else begin
          div_step_nxt = div_step_r - 1'b1;
        end
      end
      DIV_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = div_q_r;
          out_ovf_nxt   = div_ovf_r;
          div_state_nxt = DIV_IDLE;
        end
      end
      default: begin
        div_state_nxt = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      div_state_r <= div_state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    div_dsr_r  <= div_dsr_nxt;
    div_step_r <= div_step_nxt;
    div_ovf_r  <= div_ovf_nxt;
    out_mean_r <= out_mean_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign mean_magnitude = out_mean_r;
  assign frame_overflow = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME))
    else $error("sample count beyond frame limit");

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (div_state_r == DIV_RUN) && (div_step_r == '0) |=> (div_state_r == DIV_DONE))
    else $error("divider did not finish after last step");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (div_state_r == DIV_DONE) && out_valid_r && !out_ready |=> (div_state_r == DIV_DONE))
    else $error("quotient dropped while result register busy");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mean_r <= MAG_MAX))
    else $error("mean beyond largest magnitude");

endmodule

`default_nettype wire

FILE: rtl/gated_mean_complex_magnitude.sv
// ----------------------------------------------------------------------------
// gated_mean_complex_magnitude
// Mean of gated complex sample magnitudes over each frame.
// ----------------------------------------------------------------------------
// Takes one complex sample per word and delivers one mean magnitude word per
// frame, on the sample marked tlast. Samples stream at one per clock while
// in_tready is high: the magnitude pipeline (squares, sum, eight-stage square
// root) feeds a four-word queue. Each frame end starts a radix-2 divider of
// sixteen steps that hands its quotient to the result register once that is
// free; a frame end can leave the queue only while the divider is idle, so
// frames shorter than the divider's run throttle the input.
// The result register lets a mean wait for out_tready while accumulation of
// the next frame goes on. Magnitudes above a nonzero threshold are counted
// but not summed; frames longer than 4096 samples keep the mean of the first
// 4096 and raise the overflow flag.
`default_nettype none

module gated_mean_complex_magnitude
  import gmcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // [15:0] real_part, [31:16] imag_part
  input  wire logic        in_tlast,     // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [15:0] mean_magnitude
  output logic             out_tuser,    // [0] frame_overflow
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [THR_W-1:0] thr_r;
  logic             mag_valid;
  logic             mag_ready;
  mag_item_t        mag_item;
  logic             q_valid;
  mag_item_t        q_item;
  logic             q_pop;

  // one register, at byte address zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr == THR_ADDR)) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-THR_W){1'b0}}, thr_r};

  gmcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .real_part (in_tdata[15:0]),
    .imag_part (in_tdata[31:16]),
    .frame_end (in_tlast),
    .mag_valid (mag_valid),
    .mag_item  (mag_item),
    .mag_ready (mag_ready)
  );

  gmcm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (mag_valid),
    .push_ready (mag_ready),
    .push_item  (mag_item),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  gmcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (thr_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .mean_magnitude (out_tdata),
    .frame_overflow (out_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_gated_mean_complex_magnitude.sv
// ----------------------------------------------------------------------------
// tb_gated_mean_complex_magnitude
// Self-checking bench for the gated mean complex magnitude block.
// ----------------------------------------------------------------------------
// Streams complex samples into the block in frames and checks each mean word
// and its overflow flag against a behavioural model of the gated magnitude
// sum, the sample count and the frame length limit. A table of corner
// samples comes first. Random frames follow under several idling mixes and
// gate thresholds. The run closes with a trailing frame that never ends.
// ----------------------------------------------------------------------------
module tb_gated_mean_complex_magnitude
  import gmcm_pkg::*;
();

  localparam logic [1:0] THRESHOLD_ADDR = 2'd0;
  localparam int SETTLE_CYCLES          = 64;
  localparam int CYCLE_LIMIT            = 1_000_000;
  localparam int RANDOM_ITEMS_PER_PHASE = 250;
  localparam int N_CORNER               = 22;

  typedef struct packed {
    logic [15:0] mean;
    logic        overflow;
  } frame_mean_t;

  // typed rows carry their mean; the rest are checked by the model
  typedef struct packed {
    logic [15:0] gate;
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
    logic        typed;
    logic [15:0] mean;
    logic        overflow;
  } corner_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;     // [15:0] real_part, [31:16] imag_part
  logic        in_tlast    = 1'b0;   // frame_end
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;            // [15:0] mean_magnitude
  logic        out_tuser;            // [0] frame_overflow
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [1:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // model state
  logic [15:0] gate_threshold = '0;
  int unsigned frame_sum      = 0;
  int unsigned frame_samples  = 0;
  logic        frame_long     = 1'b0;

  frame_mean_t expected_means [$];
  frame_mean_t oldest_mean;

  int     idle_pct      = 0;
  int     stall_pct     = 0;
  int     fail_count    = 0;
  int     samples_sent  = 0;
  int     means_checked = 0;
  longint cycle_count   = 0;

  corner_row_t corner_rows [N_CORNER] = '{
    '{16'd0,     16'h0000, 16'h0000, 1'b1, 1'b1, 16'd0,     1'b0},  // zero sample
    '{16'd0,     16'h8000, 16'h8000, 1'b1, 1'b1, 16'd46340, 1'b0},  // largest power
    '{16'd0,     16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'd46339, 1'b0},
    '{16'd0,     16'h7FFF, 16'h0000, 1'b1, 1'b1, 16'd32767, 1'b0},
    '{16'd0,     16'h8000, 16'h0000, 1'b1, 1'b1, 16'd32768, 1'b0},
    '{16'd0,     16'h0000, 16'h8000, 1'b1, 1'b1, 16'd32768, 1'b0},
    '{16'd0,     16'h0001, 16'hFFFF, 1'b1, 1'b1, 16'd1,     1'b0},
    '{16'd0,     16'h0003, 16'h0004, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'd0,     16'hFFFA, 16'hFFF8, 1'b1, 1'b1, 16'd7,     1'b0},
    '{16'd0,     16'h1234, 16'hABCD, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'd0,     16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'd0,     16'h0FFF, 16'hF000, 1'b1, 1'b0, 16'd0,     1'b0},
    '{16'd1,     16'h0003, 16'h0004, 1'b0, 1'b0, 16'd0,     1'b0},  // gated out
    '{16'd1,     16'h0001, 16'h0000, 1'b1, 1'b1, 16'd0,     1'b0},  // still counted
    '{16'd5,     16'h0003, 16'h0004, 1'b0, 1'b0, 16'd0,     1'b0},  // equal: summed
    '{16'd5,     16'h0006, 16'h0008, 1'b1, 1'b1, 16'd2,     1'b0},
    '{16'hFFFF,  16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'hFFFF,  16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'd46340, 1'b0},
    '{16'h8000,  16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'h8000,  16'h8000, 16'h0000, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'h8000,  16'h0000, 16'h8000, 1'b0, 1'b0, 16'd0,     1'b0},
    '{16'h8000,  16'h8000, 16'h8000, 1'b1, 1'b0, 16'd0,     1'b0}
  };

  gated_mean_complex_magnitude i_dut (
    .clk,
    .rst_n,
    .in_tvalid,
    .in_tready,
    .in_tdata,
    .in_tlast,
    .out_tvalid,
    .out_tready,
    .out_tdata,
    .out_tuser,
    .cfg_psel,
    .cfg_penable,
    .cfg_pwrite,
    .cfg_paddr,
    .cfg_pwdata,
    .cfg_prdata,
    .cfg_pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // floor square root of re^2 + im^2, one root bit at a time from the top
  function automatic logic [15:0] complex_magnitude(logic [15:0] re, logic [15:0] im);
    longint unsigned power;
    longint unsigned trial;
    logic [15:0]     root;
    power = longint'($signed(re)) * longint'($signed(re))
          + longint'($signed(im)) * longint'($signed(im));
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = longint'(root | (16'd1 << b));
      if (trial * trial <= power) root = root | (16'd1 << b);
    end
    return root;
  endfunction

  // update the frame state with one sample; returns 1 when a mean is due
  function automatic bit fold_sample(input logic [15:0] re, input logic [15:0] im,
                                     input logic last, output frame_mean_t result);
    logic [15:0] mag;
    mag    = complex_magnitude(re, im);
    result = '0;
    if (frame_samples >= MAX_FRAME) begin
      frame_long = 1'b1;
    end else begin
      frame_samples++;
      if (!(gate_threshold != 0 && mag > gate_threshold)) begin
        frame_sum += mag;
        if (frame_sum > SUM_MAX) frame_sum = SUM_MAX;
      end
    end
    if (!last) return 1'b0;
    result.mean     = 16'(frame_samples != 0 ? frame_sum / frame_samples : 0);
    result.overflow = frame_long;
    frame_sum     = 0;
    frame_samples = 0;
    frame_long    = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 63) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int frame_length();
    case ($urandom_range(0, 9))
      0, 1, 2:          return 1;
      3, 4, 5, 6, 7:    return $urandom_range(2, 16);
      8:                return $urandom_range(17, 60);
      default:          return $urandom_range(61, 200);
    endcase
  endfunction

  task automatic write_threshold(logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= THRESHOLD_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    gate_threshold = value;
    // straight into a read-back transfer
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value) begin
      $display("%0t: threshold read-back expected %0d, got %0d", $time, value,
               cfg_prdata[15:0]);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // hold the word until accepted, after a random idle gap
  task automatic push_sample(logic [15:0] re, logic [15:0] im, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic stream_sample(logic [15:0] re, logic [15:0] im, logic last);
    frame_mean_t res;
    push_sample(re, im, last);
    if (fold_sample(re, im, last, res)) expected_means.push_back(res);
  endtask

  task automatic wait_for_means();
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  // empty the block before touching the register or finishing
  task automatic settle_block();
    in_tvalid <= 1'b0;
    wait_for_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected mean word %0d, overflow %0b", $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        oldest_mean = expected_means.pop_front();
        means_checked++;
        if (out_tdata !== oldest_mean.mean) begin
          $display("%0t: mean expected %0d, got %0d", $time, oldest_mean.mean, out_tdata);
          fail_count++;
        end
        if (out_tuser !== oldest_mean.overflow) begin
          $display("%0t: overflow expected %0b, got %0b", $time, oldest_mean.overflow,
                   out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    corner_row_t row;
    frame_mean_t res;
    logic [15:0] phase_gate;
    int          sent;
    int          len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_threshold(16'd0);

    foreach (corner_rows[n]) begin
      row = corner_rows[n];
      if (row.gate !== gate_threshold) begin
        settle_block();
        write_threshold(row.gate);
      end
      push_sample(row.re, row.im, row.last);
      if (fold_sample(row.re, row.im, row.last, res)) begin
        if (row.typed) begin
          res.mean     = row.mean;
          res.overflow = row.overflow;
        end
        expected_means.push_back(res);
      end
    end

    for (int p = 0; p < 4; p++) begin
      settle_block();
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  phase_gate = 16'($urandom); end
        1: begin idle_pct = 83; stall_pct = 0;  phase_gate = 16'd0; end
        2: begin idle_pct = 0;  stall_pct = 83; phase_gate = 16'hFFFF; end
        default: begin
          idle_pct = 15; stall_pct = 15; phase_gate = 16'($urandom_range(1, 2000));
        end
      endcase
      write_threshold(phase_gate);
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_PHASE) begin
        len = frame_length();
        for (int k = 1; k <= len; k++)
          stream_sample(random_component(), random_component(), k == len);
        sent += len;
        // now and then hold the input until every mean is out
        if ($urandom_range(0, 24) == 0) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          wait_for_means();
        end
      end
    end

    // a frame that never ends must produce nothing
    settle_block();
    for (int k = 0; k < 5; k++) stream_sample(random_component(), random_component(), 1'b0);
    settle_block();

    if (expected_means.size() != 0) begin
      $display("%0t: %0d mean words never arrived", $time, expected_means.size());
      fail_count++;
    end
    $display("Sent %0d samples across four idling mixes and several gate thresholds;",
             samples_sent);
    $display("checked %0d frame means together with their overflow flags.",
             means_checked);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/gmcm_pkg.sv
rtl/gmcm_front.sv
rtl/gmcm_fifo.sv
rtl/gmcm_back.sv
rtl/gated_mean_complex_magnitude.sv
tb/sv/tb_gated_mean_complex_magnitude.sv
